// ===== hdl/qpy_pkg.sv =====
package qpy_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int FRAC_BITS_DEF     = 14;

    localparam int QUAT_W    = 16;
    localparam int PROD_W    = 2 * QUAT_W;
    localparam int WORK_FRAC = 30;
    localparam int SW_W      = WORK_FRAC + 2;
    localparam int ROOT_W    = WORK_FRAC + 1;
    localparam int RAD_W     = 2 * WORK_FRAC + 1;
    localparam int SQRT_LAT  = ROOT_W + 2;

    localparam int NORM_EXP   = 39;
    localparam int NORM_STEPS = 6;

    localparam int ATAN_LEN   = 24;
    localparam int ZW         = 26;
    localparam int ROUND_HALF = 256;
    localparam int ROUND_SH   = 9;
    localparam int QUARTER    = 90 * 65536;

    localparam int PITCH_W   = 15;
    localparam int YAW_W     = 16;
    localparam int PITCH_MAX = 11520;
    localparam int YAW_MAX   = 23040;

    typedef struct packed {
        logic valid;
        logic clamped;
    } qpy_ctl_t;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic signed [ZW-1:0] atan_deg16(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = ZW'(2949120);
            5'd1:    v = ZW'(1740967);
            5'd2:    v = ZW'(919879);
            5'd3:    v = ZW'(466945);
            5'd4:    v = ZW'(234379);
            5'd5:    v = ZW'(117304);
            5'd6:    v = ZW'(58666);
            5'd7:    v = ZW'(29335);
            5'd8:    v = ZW'(14668);
            5'd9:    v = ZW'(7334);
            5'd10:   v = ZW'(3667);
            5'd11:   v = ZW'(1833);
            5'd12:   v = ZW'(917);
            5'd13:   v = ZW'(458);
            5'd14:   v = ZW'(229);
            5'd15:   v = ZW'(115);
            5'd16:   v = ZW'(57);
            5'd17:   v = ZW'(29);
            5'd18:   v = ZW'(14);
            5'd19:   v = ZW'(7);
            5'd20:   v = ZW'(4);
            5'd21:   v = ZW'(2);
            5'd22:   v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/qpy_front.sv =====
module qpy_front #(
    parameter int FRAC_BITS = qpy_pkg::FRAC_BITS_DEF,
    parameter int OPW       = 35
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                valid_in,
    input  logic signed [qpy_pkg::QUAT_W-1:0]   w,
    input  logic signed [qpy_pkg::QUAT_W-1:0]   x,
    input  logic signed [qpy_pkg::QUAT_W-1:0]   y,
    input  logic signed [qpy_pkg::QUAT_W-1:0]   z,
    output qpy_pkg::qpy_ctl_t                   ctl_out,
    output logic signed [qpy_pkg::SW_W-1:0]     sw,
    output logic signed [OPW-1:0]               num,
    output logic signed [OPW-1:0]               den
);
    import qpy_pkg::*;

    localparam logic signed [OPW-1:0] ONE = {{(OPW-1){1'b0}}, 1'b1} << (2 * FRAC_BITS);
    localparam int SH_R = (2 * FRAC_BITS >= WORK_FRAC) ? 2 * FRAC_BITS - WORK_FRAC : 0;
    localparam int SH_L = (2 * FRAC_BITS < WORK_FRAC) ? WORK_FRAC - 2 * FRAC_BITS : 0;

    // stage 1: products
    logic signed [PROD_W-1:0] wy_reg, xz_reg, wz_reg, xy_reg, yy_reg, zz_reg;
    logic                     v1_reg;

    // stage 2: sine, yaw operands
    logic signed [OPW-1:0]  s_full, s_sat, sw_wide, num_next, den_next;
    logic signed [SW_W-1:0] sw_next;
    logic                   cl_next;
    logic signed [SW_W-1:0] sw_reg;
    logic signed [OPW-1:0]  num_reg, den_reg;
    qpy_ctl_t               ctl_reg;

    always_ff @(posedge clk)
    begin
        wy_reg <= w * y;
        xz_reg <= x * z;
        wz_reg <= w * z;
        xy_reg <= x * y;
        yy_reg <= y * y;
        zz_reg <= z * z;
    end

    always_comb
    begin
        s_full = (OPW'(wy_reg) - OPW'(xz_reg)) <<< 1;
        cl_next = 1'b0;
        if (s_full > ONE)
        begin
            s_sat   = ONE;
            cl_next = 1'b1;
        end
        else if (s_full < -ONE)
        begin
            s_sat   = -ONE;
            cl_next = 1'b1;
        end
        else
        begin
            s_sat = s_full;
        end
        sw_wide  = (s_sat >>> SH_R) <<< SH_L;
        sw_next  = SW_W'(sw_wide);
        num_next = (OPW'(wz_reg) + OPW'(xy_reg)) <<< 1;
        den_next = ONE - ((OPW'(yy_reg) + OPW'(zz_reg)) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        sw_reg  <= sw_next;
        num_reg <= num_next;
        den_reg <= den_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            ctl_reg <= '0;
        end
        else
        begin
            v1_reg          <= valid_in;
            ctl_reg.valid   <= v1_reg;
            ctl_reg.clamped <= cl_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign sw      = sw_reg;
    assign num     = num_reg;
    assign den     = den_reg;

endmodule

// ===== hdl/qpy_isqrt.sv =====
module qpy_isqrt (
    input  logic                              clk,
    input  logic                              rst_n,
    input  qpy_pkg::qpy_ctl_t                 ctl_in,
    input  logic signed [qpy_pkg::SW_W-1:0]   sw_in,
    output qpy_pkg::qpy_ctl_t                 ctl_out,
    output logic signed [qpy_pkg::SW_W-1:0]   sw_out,
    output logic [qpy_pkg::ROOT_W-1:0]        root
);
    import qpy_pkg::*;

    localparam int RW = RAD_W + 1;
    localparam logic [RAD_W-1:0] FULL = {1'b1, {(RAD_W-1){1'b0}}};

    // stage a: square of the sine
    logic signed [SW_W-1:0]   sw_abs;
    logic [2*ROOT_W-1:0]      sq_reg;
    logic signed [SW_W-1:0]   swa_reg;
    qpy_ctl_t                 ctla_reg;

    // root steps, one result bit each
    logic [RAD_W-1:0]         n_reg   [0:ROOT_W];
    logic [RW-1:0]            r_reg   [0:ROOT_W];
    logic signed [SW_W-1:0]   sws_reg [0:ROOT_W];
    qpy_ctl_t                 ctl_reg [0:ROOT_W];
    logic [RAD_W-1:0]         n_next  [1:ROOT_W];
    logic [RW-1:0]            r_next  [1:ROOT_W];

    assign sw_abs = sw_in[SW_W-1] ? -sw_in : sw_in;

    always_ff @(posedge clk)
    begin
        sq_reg     <= sw_abs[ROOT_W-1:0] * sw_abs[ROOT_W-1:0];
        swa_reg    <= sw_in;
        n_reg[0]   <= FULL - sq_reg[RAD_W-1:0];
        r_reg[0]   <= '0;
        sws_reg[0] <= swa_reg;
        for (int j = 0; j < ROOT_W; j++)
        begin
            n_reg[j+1]   <= n_next[j+1];
            r_reg[j+1]   <= r_next[j+1];
            sws_reg[j+1] <= sws_reg[j];
        end
    end

    always_comb
    begin
        logic [RW:0]   trial;
        logic [RW-1:0] bitv;
        for (int j = 0; j < ROOT_W; j++)
        begin
            bitv  = RW'(1) << (2 * (ROOT_W - 1 - j));
            trial = {1'b0, r_reg[j]} + {1'b0, bitv};
            if ({2'b00, n_reg[j]} >= trial)
            begin
                n_next[j+1] = n_reg[j] - trial[RAD_W-1:0];
                r_next[j+1] = (r_reg[j] >> 1) + bitv;
            end
            else
            begin
                n_next[j+1] = n_reg[j];
                r_next[j+1] = r_reg[j] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctla_reg <= '0;
            for (int j = 0; j <= ROOT_W; j++)
            begin
                ctl_reg[j] <= '0;
            end
        end
        else
        begin
            ctla_reg   <= ctl_in;
            ctl_reg[0] <= ctla_reg;
            for (int j = 0; j < ROOT_W; j++)
            begin
                ctl_reg[j+1] <= ctl_reg[j];
            end
        end
    end

    assign ctl_out = ctl_reg[ROOT_W];
    assign sw_out  = sws_reg[ROOT_W];
    assign root    = r_reg[ROOT_W][ROOT_W-1:0];

endmodule

// ===== hdl/qpy_norm.sv =====
module qpy_norm #(
    parameter int IN_W = 35,
    parameter int NW   = 41
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  qpy_pkg::qpy_ctl_t      ctl_in,
    input  logic signed [IN_W-1:0] x_in,
    input  logic signed [IN_W-1:0] y_in,
    output qpy_pkg::qpy_ctl_t      ctl_out,
    output logic signed [NW-1:0]   x_out,
    output logic signed [NW-1:0]   y_out,
    output logic                   zero_out
);
    import qpy_pkg::*;

    logic signed [NW-1:0] x_ext, y_ext, x_abs, y_abs;
    logic signed [NW-1:0] x_reg    [0:NORM_STEPS];
    logic signed [NW-1:0] y_reg    [0:NORM_STEPS];
    logic [NW-1:0]        mag_reg  [0:NORM_STEPS];
    logic                 zero_reg [0:NORM_STEPS];
    qpy_ctl_t             ctl_reg  [0:NORM_STEPS];
    logic signed [NW-1:0] x_next   [1:NORM_STEPS];
    logic signed [NW-1:0] y_next   [1:NORM_STEPS];
    logic [NW-1:0]        mag_next [1:NORM_STEPS];

    always_comb
    begin
        x_ext = NW'(x_in);
        y_ext = NW'(y_in);
        x_abs = x_ext[NW-1] ? -x_ext : x_ext;
        y_abs = y_ext[NW-1] ? -y_ext : y_ext;
    end

    // shift by 32, 16, ... 1 while the larger magnitude stays below 2^40,
    // so a nonzero magnitude below 2^39 ends in [2^39, 2^40)
    always_comb
    begin
        logic [NW-1:0] thr;
        int            k;
        for (int s = 0; s < NORM_STEPS; s++)
        begin
            k   = 1 << (NORM_STEPS - 1 - s);
            thr = NW'(1) << (NORM_EXP + 1 - k);
            if (mag_reg[s] < thr)
            begin
                x_next[s+1]   = x_reg[s] <<< k;
                y_next[s+1]   = y_reg[s] <<< k;
                mag_next[s+1] = mag_reg[s] << k;
            end
            else
            begin
                x_next[s+1]   = x_reg[s];
                y_next[s+1]   = y_reg[s];
                mag_next[s+1] = mag_reg[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= x_ext;
        y_reg[0]    <= y_ext;
        mag_reg[0]  <= (x_abs > y_abs) ? x_abs : y_abs;
        zero_reg[0] <= (x_in == '0) && (y_in == '0);
        for (int s = 0; s < NORM_STEPS; s++)
        begin
            x_reg[s+1]    <= x_next[s+1];
            y_reg[s+1]    <= y_next[s+1];
            mag_reg[s+1]  <= mag_next[s+1];
            zero_reg[s+1] <= zero_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= NORM_STEPS; s++)
            begin
                ctl_reg[s] <= '0;
            end
        end
        else
        begin
            ctl_reg[0] <= ctl_in;
            for (int s = 0; s < NORM_STEPS; s++)
            begin
                ctl_reg[s+1] <= ctl_reg[s];
            end
        end
    end

    assign ctl_out  = ctl_reg[NORM_STEPS];
    assign x_out    = x_reg[NORM_STEPS];
    assign y_out    = y_reg[NORM_STEPS];
    assign zero_out = zero_reg[NORM_STEPS];

endmodule

// ===== hdl/qpy_cordic.sv =====
module qpy_cordic #(
    parameter int NW     = 41,
    parameter int STAGES = qpy_pkg::CORDIC_STAGES_DEF,
    parameter int OUT_W  = qpy_pkg::YAW_W,
    parameter int LIMIT  = qpy_pkg::YAW_MAX
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  qpy_pkg::qpy_ctl_t       ctl_in,
    input  logic signed [NW-1:0]    x_in,
    input  logic signed [NW-1:0]    y_in,
    input  logic                    zero_in,
    output qpy_pkg::qpy_ctl_t       ctl_out,
    output logic signed [OUT_W-1:0] angle
);
    import qpy_pkg::*;

    localparam int CW = NW + 2;
    localparam int N  = (STAGES > ATAN_LEN) ? ATAN_LEN : STAGES;
    localparam logic signed [ZW-1:0] LIM = ZW'(LIMIT);
    localparam logic signed [ZW-1:0] QTR = ZW'(QUARTER);

    logic signed [CW-1:0]    x_reg    [0:N];
    logic signed [CW-1:0]    y_reg    [0:N];
    logic signed [ZW-1:0]    z_reg    [0:N];
    logic                    zero_reg [0:N];
    qpy_ctl_t                ctl_reg  [0:N];
    logic signed [CW-1:0]    x_next   [0:N];
    logic signed [CW-1:0]    y_next   [0:N];
    logic signed [ZW-1:0]    z_next   [0:N];
    logic signed [CW-1:0]    xe, ye;
    logic signed [ZW-1:0]    v;
    logic signed [OUT_W-1:0] angle_next, angle_reg;
    qpy_ctl_t                ctl_o_reg;

    // quarter-turn pre-rotation into the right half plane
    always_comb
    begin
        xe = CW'(x_in);
        ye = CW'(y_in);
        if (xe < 0)
        begin
            if (ye >= 0)
            begin
                x_next[0] = ye;
                y_next[0] = -xe;
                z_next[0] = QTR;
            end
            else
            begin
                x_next[0] = -ye;
                y_next[0] = xe;
                z_next[0] = -QTR;
            end
        end
        else
        begin
            x_next[0] = xe;
            y_next[0] = ye;
            z_next[0] = '0;
        end
    end

    // vectoring micro-rotations, one per stage
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            if (y_reg[i] > 0)
            begin
                x_next[i+1] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] + atan_deg16(5'(i));
            end
            else
            begin
                x_next[i+1] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] - atan_deg16(5'(i));
            end
        end
    end

    // round to 1/128 degree and saturate; a zero vector gives 0
    always_comb
    begin
        v = (z_reg[N] + ZW'(ROUND_HALF)) >>> ROUND_SH;
        if (v > LIM)
        begin
            v = LIM;
        end
        else if (v < -LIM)
        begin
            v = -LIM;
        end
        angle_next = zero_reg[N] ? '0 : OUT_W'(v);
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= x_next[0];
        y_reg[0]    <= y_next[0];
        z_reg[0]    <= z_next[0];
        zero_reg[0] <= zero_in;
        for (int i = 0; i < N; i++)
        begin
            x_reg[i+1]    <= x_next[i+1];
            y_reg[i+1]    <= y_next[i+1];
            z_reg[i+1]    <= z_next[i+1];
            zero_reg[i+1] <= zero_reg[i];
        end
        angle_reg <= angle_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= N; i++)
            begin
                ctl_reg[i] <= '0;
            end
            ctl_o_reg <= '0;
        end
        else
        begin
            ctl_reg[0] <= ctl_in;
            for (int i = 0; i < N; i++)
            begin
                ctl_reg[i+1] <= ctl_reg[i];
            end
            ctl_o_reg <= ctl_reg[N];
        end
    end

    assign ctl_out = ctl_o_reg;
    assign angle   = angle_reg;

endmodule

// ===== hdl/quaternion_to_pitch_yaw.sv =====
// throughput: one quaternion per cycle, busy stays low, done pulses once per transaction
// the path runs through the bit-per-stage square root, then the normalizer and the cordic chain
// reset: rst_n clears every valid bit at once, so no done appears for work in flight
// the receiver cannot stall; each result sits on the ports for exactly the done cycle
module quaternion_to_pitch_yaw #(
    parameter int CORDIC_STAGES = qpy_pkg::CORDIC_STAGES_DEF,
    parameter int FRAC_BITS     = qpy_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [qpy_pkg::QUAT_W-1:0]   quat_w,
    input  logic signed [qpy_pkg::QUAT_W-1:0]   quat_x,
    input  logic signed [qpy_pkg::QUAT_W-1:0]   quat_y,
    input  logic signed [qpy_pkg::QUAT_W-1:0]   quat_z,
    output logic                                done,
    output logic signed [qpy_pkg::PITCH_W-1:0]  pitch_angle,
    output logic signed [qpy_pkg::YAW_W-1:0]    yaw_angle,
    output logic                                pitch_clamped
);
    import qpy_pkg::*;

    // operand width: 1.0 squared plus headroom, never below 35 bits for the doubled product sums of up to 2^32
    localparam int OPW = (2 * FRAC_BITS + 2 > 35) ? 2 * FRAC_BITS + 2 : 35;
    // normalized magnitude lands at or above 2^39
    localparam int NW  = (OPW > NORM_EXP + 2) ? OPW : NORM_EXP + 2;

    qpy_ctl_t               f_ctl, s_ctl, pn_ctl, yn_ctl, p_ctl;
    logic signed [SW_W-1:0] f_sw, s_sw;
    logic signed [OPW-1:0]  f_num, f_den;
    logic [ROOT_W-1:0]      s_root;
    logic signed [OPW-1:0]  p_x, p_y;
    logic signed [NW-1:0]   pn_x, pn_y, yn_x, yn_y;
    logic                   pn_zero, yn_zero;

    // yaw operands wait in a shift line while the pitch cosine is formed
    logic signed [OPW-1:0]  num_dly_reg [0:SQRT_LAT-1];
    logic signed [OPW-1:0]  den_dly_reg [0:SQRT_LAT-1];

    // never holds off a transaction: a new quaternion can enter every cycle
    assign busy = 1'b0;

    // products, sine clamp, yaw numerator and denominator
    qpy_front #(
        .FRAC_BITS (FRAC_BITS),
        .OPW       (OPW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (start),
        .w        (quat_w),
        .x        (quat_x),
        .y        (quat_y),
        .z        (quat_z),
        .ctl_out  (f_ctl),
        .sw       (f_sw),
        .num      (f_num),
        .den      (f_den)
    );

    // cosine = floor(sqrt(2^60 - s^2))
    qpy_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (f_ctl),
        .sw_in   (f_sw),
        .ctl_out (s_ctl),
        .sw_out  (s_sw),
        .root    (s_root)
    );

    always_ff @(posedge clk)
    begin
        num_dly_reg[0] <= f_num;
        den_dly_reg[0] <= f_den;
        for (int i = 1; i < SQRT_LAT; i++)
        begin
            num_dly_reg[i] <= num_dly_reg[i-1];
            den_dly_reg[i] <= den_dly_reg[i-1];
        end
    end

    assign p_y = OPW'(s_sw);
    assign p_x = {{(OPW-ROOT_W){1'b0}}, s_root};

    // pitch = atan2(s, c)
    qpy_norm #(
        .IN_W (OPW),
        .NW   (NW)
    ) u_norm_pitch (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (s_ctl),
        .x_in     (p_x),
        .y_in     (p_y),
        .ctl_out  (pn_ctl),
        .x_out    (pn_x),
        .y_out    (pn_y),
        .zero_out (pn_zero)
    );

    qpy_cordic #(
        .NW     (NW),
        .STAGES (CORDIC_STAGES),
        .OUT_W  (PITCH_W),
        .LIMIT  (PITCH_MAX)
    ) u_cordic_pitch (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (pn_ctl),
        .x_in    (pn_x),
        .y_in    (pn_y),
        .zero_in (pn_zero),
        .ctl_out (p_ctl),
        .angle   (pitch_angle)
    );

    // yaw = atan2(num, den), same timing as the pitch path
    qpy_norm #(
        .IN_W (OPW),
        .NW   (NW)
    ) u_norm_yaw (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (s_ctl),
        .x_in     (den_dly_reg[SQRT_LAT-1]),
        .y_in     (num_dly_reg[SQRT_LAT-1]),
        .ctl_out  (yn_ctl),
        .x_out    (yn_x),
        .y_out    (yn_y),
        .zero_out (yn_zero)
    );

    qpy_cordic #(
        .NW     (NW),
        .STAGES (CORDIC_STAGES),
        .OUT_W  (YAW_W),
        .LIMIT  (YAW_MAX)
    ) u_cordic_yaw (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (yn_ctl),
        .x_in    (yn_x),
        .y_in    (yn_y),
        .zero_in (yn_zero),
        .ctl_out (),
        .angle   (yaw_angle)
    );

    // strobe and flag ride with the pitch path
    assign done          = p_ctl.valid;
    assign pitch_clamped = p_ctl.clamped;

endmodule

// ===== test/qpy_checker.sv =====
`timescale 1ns / 1ps

module qpy_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic signed [qpy_pkg::QUAT_W-1:0]   quat_w,
    input  logic signed [qpy_pkg::QUAT_W-1:0]   quat_x,
    input  logic signed [qpy_pkg::QUAT_W-1:0]   quat_y,
    input  logic signed [qpy_pkg::QUAT_W-1:0]   quat_z,
    input  logic                                done,
    input  logic signed [qpy_pkg::PITCH_W-1:0]  pitch_angle,
    input  logic signed [qpy_pkg::YAW_W-1:0]    yaw_angle,
    input  logic                                pitch_clamped,
    output int                                  fail_count,
    output int                                  pending
);
    import qpy_pkg::*;

    typedef struct packed {
        logic signed [PITCH_W-1:0] pitch;
        logic signed [YAW_W-1:0]   yaw;
        logic                      clamped;
    } angles_t;

    localparam int STAGES = CORDIC_STAGES_DEF;
    localparam int FRAC   = FRAC_BITS_DEF;

    angles_t angle_q[$];

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_step(int i);
        longint t[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4,
            2, 1, 0};
        return t[i];
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, t, dx, dy, mag, ax, ay;
        int n;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        mag = ax > ay ? ax : ay;
        while (mag < (64'sd1 <<< 39))
        begin
            x = x * 2; y = y * 2; mag = mag * 2;
        end
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = 90 * 65536;
            end
            else
            begin
                t = x; x = -y; y = t; z = -90 * 65536;
            end
        end
        n = STAGES > 24 ? 24 : STAGES;
        for (int i = 0; i < n; i++)
        begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (y > 0)
            begin
                x += dx; y -= dy; z += atan_step(i);
            end
            else
            begin
                x -= dx; y += dy; z -= atan_step(i);
            end
        end
        return z;
    endfunction

    function automatic longint to_units(longint d, longint lim);
        longint v;
        v = fshr(d + 256, 9);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v;
    endfunction

    function automatic angles_t predict_angles(longint w, longint x, longint y, longint z);
        angles_t r;
        longint one, s, sw, c, num, den;
        one = 64'sd1 <<< (2 * FRAC);
        r.clamped = 1'b0;
        s = 2 * (w * y - x * z);
        if (s > one)
        begin
            s = one; r.clamped = 1'b1;
        end
        else if (s < -one)
        begin
            s = -one; r.clamped = 1'b1;
        end
        if (2 * FRAC >= 30)
            sw = fshr(s, 2 * FRAC - 30);
        else
            sw = s * (64'sd1 <<< (30 - 2 * FRAC));
        c = int_sqrt((64'd1 << 60) - longint'(sw * sw));
        r.pitch = PITCH_W'(to_units(vector_angle(sw, c), PITCH_MAX));
        num = 2 * (w * z + x * y);
        den = one - 2 * (y * y + z * z);
        r.yaw = YAW_W'(to_units(vector_angle(num, den), YAW_MAX));
        return r;
    endfunction

    assign pending = angle_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        angles_t e;
        if (!rst_n)
        begin
            fail_count <= 0;
            angle_q.delete();
        end
        else
        begin
            if (start && !busy)
                angle_q.push_back(predict_angles(quat_w, quat_x, quat_y, quat_z));
            if (done)
            begin
                if (angle_q.size() == 0)
                begin
                    $display("%0t: unexpected result p=%0d y=%0d c=%0b", $time,
                             pitch_angle, yaw_angle, pitch_clamped);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = angle_q.pop_front();
                    if (e.pitch !== pitch_angle || e.yaw !== yaw_angle
                        || e.clamped !== pitch_clamped)
                    begin
                        $display("%0t: mismatch expected p=%0d y=%0d c=%0b actual p=%0d y=%0d c=%0b",
                                 $time, e.pitch, e.yaw, e.clamped,
                                 pitch_angle, yaw_angle, pitch_clamped);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import qpy_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [QUAT_W-1:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
    logic done;
    logic signed [PITCH_W-1:0] pitch_angle;
    logic signed [YAW_W-1:0] yaw_angle;
    logic pitch_clamped;
    int fail_count, pending;
    int cycles = 0;

    localparam int CYCLE_LIMIT = 200000;

    always #5 clk = ~clk;

    quaternion_to_pitch_yaw u_dut (.*);

    qpy_checker u_chk (.*);

    // timeout watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // random component: mostly within +-1.0, biased toward +-1.0 and zero, sometimes any 16-bit value
    function automatic logic [15:0] pick_comp();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 16'(16384);
        if (k == 1) return 16'(-16384);
        if (k == 2) return 16'($urandom());
        if (k == 3) return 16'h0;
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    // one transaction; start drops only while idling between items
    task automatic send(input logic [15:0] w, x, y, z, input bit gaps);
        if (gaps)
            while ($urandom_range(0, 99) < 35)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        start <= 1'b1;
        quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: axes, extremes, clamp, zero, negative x axis
        send(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        send(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        send(16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b0);
        send(16'sd11585, 16'sd0, 16'sd11585, 16'sd0, 1'b0);
        send(16'sd11585, 16'sd0, -16'sd11585, 16'sd0, 1'b0);
        send(16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 1'b0);
        send(-16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 1'b0);
        send(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 1'b0);
        send(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, 1'b0);
        send(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b0);
        send(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1'b0);
        send(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0);
        send(16'sd0, 16'sd16384, 16'sd0, 16'sd0, 1'b0);
        send(16'sd0, 16'sd0, 16'sd16384, 16'sd0, 1'b0);
        send(16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 1'b0);
        send(16'sd11585, 16'sd0, 16'sd0, -16'sd11585, 1'b0);
        send(16'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        // random: a stretch with no idling, then idling
        for (int i = 0; i < 1300; i++)
            send(pick_comp(), pick_comp(), pick_comp(), pick_comp(), i > 300);
        start <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/qpy_pkg.sv
hdl/qpy_front.sv
hdl/qpy_isqrt.sv
hdl/qpy_norm.sv
hdl/qpy_cordic.sv
hdl/quaternion_to_pitch_yaw.sv
test/qpy_checker.sv
test/tb_top.sv
